FILE: rtl/core/scs_pkg.sv
// shared types, constants and lookup functions of the six-step commutation sweeper
package scs_pkg;

  localparam int unsigned SectorCount   = 6;
  localparam int unsigned SweepMax      = 16;
  localparam int unsigned ElapsedMax    = 1023;
  localparam int unsigned BlinkOnMs     = 200;
  localparam int unsigned BlinkOffMs    = 200;
  localparam int unsigned BlinkPauseMs  = 800;
  localparam int unsigned BlinkPeriodMs = BlinkOnMs + BlinkOffMs + BlinkOnMs + BlinkPauseMs;
  localparam int unsigned AddrWidth     = 5;
  localparam int unsigned DataWidth     = 32;

  // register index, byte address divided by four
  typedef enum logic [2:0] {
    REG_DWELL_START     = 3'd0,
    REG_DWELL_INCREMENT = 3'd1,
    REG_DWELL_COUNT     = 3'd2,
    REG_STEPS_PER_DWELL = 3'd3,
    REG_REVERSE         = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [5:0]  dwell_start_ms;
    logic [5:0]  dwell_increment_ms;
    logic [4:0]  dwell_count;
    logic [11:0] steps_per_dwell;
    logic        reverse_direction;
  } cfg_t;

  // gates: bit0 ah, bit1 al, bit2 bh, bit3 bl, bit4 ch, bit5 cl
  typedef struct packed {
    logic [5:0] gates;
    logic       status_led;
    logic       commutated;
    logic       safe_mode;
    logic [2:0] active_sector;
    logic [9:0] current_dwell_ms;
  } result_t;

  function automatic logic [5:0] sector_gates(input logic [2:0] sector);
    logic [5:0] g;
    case (sector)
      3'd0:    g = 6'h09;
      3'd1:    g = 6'h21;
      3'd2:    g = 6'h24;
      3'd3:    g = 6'h06;
      3'd4:    g = 6'h12;
      3'd5:    g = 6'h18;
      default: g = 6'h00;
    endcase
    return g;
  endfunction

  // dwell of one sweep entry, a computed zero counts as one
  function automatic logic [9:0] dwell_of(input cfg_t cfg, input logic [3:0] idx);
    logic [9:0] d;
    d = {4'b0, cfg.dwell_start_ms} + (10'(idx) * 10'(cfg.dwell_increment_ms));
    return (d == 10'd0) ? 10'd1 : d;
  endfunction

  function automatic logic blink_level(input logic [10:0] phase);
    logic lvl;
    if (phase < 11'(BlinkOnMs)) begin
      lvl = 1'b1;
    end else if (phase < 11'(BlinkOnMs + BlinkOffMs)) begin
      lvl = 1'b0;
    end else if (phase < 11'(BlinkOnMs + BlinkOffMs + BlinkOnMs)) begin
      lvl = 1'b1;
    end else begin
      lvl = 1'b0;
    end
    return lvl;
  endfunction

endpackage

FILE: rtl/core/scs_regs.sv
// configuration register file behind the apb-style port
module scs_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [scs_pkg::AddrWidth-1:0]    paddr,
  input  logic [scs_pkg::DataWidth-1:0]    pwdata,
  output logic [scs_pkg::DataWidth-1:0]    prdata,
  output logic                             pready,
  output scs_pkg::cfg_t                    cfg
);

  scs_pkg::cfg_t    regs;
  scs_pkg::reg_idx_t idx;
  logic             wr;

  assign idx    = scs_pkg::reg_idx_t'(paddr[scs_pkg::AddrWidth-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dwell_start_ms     <= 6'd5;
      regs.dwell_increment_ms <= 6'd5;
      regs.dwell_count        <= 5'd10;
      regs.steps_per_dwell    <= 12'd240;
      regs.reverse_direction  <= 1'b1;
    end else if (wr) begin
      case (idx)
        scs_pkg::REG_DWELL_START:     regs.dwell_start_ms     <= pwdata[5:0];
        scs_pkg::REG_DWELL_INCREMENT: regs.dwell_increment_ms <= pwdata[5:0];
        scs_pkg::REG_DWELL_COUNT:     regs.dwell_count        <= pwdata[4:0];
        scs_pkg::REG_STEPS_PER_DWELL: regs.steps_per_dwell    <= pwdata[11:0];
        scs_pkg::REG_REVERSE:         regs.reverse_direction  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      scs_pkg::REG_DWELL_START:     prdata = 32'(regs.dwell_start_ms);
      scs_pkg::REG_DWELL_INCREMENT: prdata = 32'(regs.dwell_increment_ms);
      scs_pkg::REG_DWELL_COUNT:     prdata = 32'(regs.dwell_count);
      scs_pkg::REG_STEPS_PER_DWELL: prdata = 32'(regs.steps_per_dwell);
      scs_pkg::REG_REVERSE:         prdata = 32'(regs.reverse_direction);
      default:                      prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/scs_core.sv
// commutation, sweep and safe-mode state with its single-pass update logic
module scs_core (
  input  logic             clk,
  input  logic             rst,
  input  scs_pkg::cfg_t    cfg,
  input  logic             accept,
  input  logic             fault_n,
  output scs_pkg::result_t result_next
);

  logic [2:0]  next_sector, next_sector_next;
  logic [2:0]  shown_sector, shown_sector_next;
  logic        gates_on, gates_on_next;
  logic [9:0]  elapsed_ms, elapsed_ms_next;
  logic [3:0]  sweep_index, sweep_index_next;
  logic [11:0] steps_at_dwell, steps_at_dwell_next;
  logic        fault_latch, fault_latch_next;
  logic [10:0] blink_phase, blink_phase_next;
  logic        led_level, led_level_next;

  logic [4:0]  count_eff;
  logic [11:0] spd_eff;
  logic [3:0]  idx_inc, idx_adv;
  logic [9:0]  dwell_now, dwell_adv;
  logic [9:0]  elapsed_inc;
  logic [11:0] steps_inc;
  logic        due, step_wrap, stepped, idx_moved;

  always_comb begin
    if (cfg.dwell_count == 5'd0) begin
      count_eff = 5'd1;
    end else if (cfg.dwell_count > 5'(scs_pkg::SweepMax)) begin
      count_eff = 5'(scs_pkg::SweepMax);
    end else begin
      count_eff = cfg.dwell_count;
    end
    spd_eff = (cfg.steps_per_dwell == 12'd0) ? 12'd1 : cfg.steps_per_dwell;
    idx_inc = sweep_index + 4'd1;
    idx_adv = ({1'b0, idx_inc} >= count_eff) ? 4'd0 : idx_inc;
  end

  // both candidate dwells come straight from registers
  assign dwell_now   = scs_pkg::dwell_of(cfg, sweep_index);
  assign dwell_adv   = scs_pkg::dwell_of(cfg, idx_adv);
  assign elapsed_inc = (elapsed_ms < 10'(scs_pkg::ElapsedMax)) ? elapsed_ms + 10'd1 : elapsed_ms;
  assign due         = elapsed_inc >= dwell_now;
  assign steps_inc   = steps_at_dwell + 12'd1;
  assign step_wrap   = steps_inc >= spd_eff;

  always_comb begin
    next_sector_next    = next_sector;
    shown_sector_next   = shown_sector;
    gates_on_next       = gates_on;
    elapsed_ms_next     = elapsed_ms;
    sweep_index_next    = sweep_index;
    steps_at_dwell_next = steps_at_dwell;
    fault_latch_next    = fault_latch;
    blink_phase_next    = blink_phase;
    led_level_next      = led_level;
    stepped             = 1'b0;
    idx_moved           = 1'b0;
    if (fault_latch) begin
      blink_phase_next = (blink_phase == 11'(scs_pkg::BlinkPeriodMs - 1)) ? 11'd0
                                                                           : blink_phase + 11'd1;
      led_level_next   = scs_pkg::blink_level(blink_phase_next);
    end else if (!fault_n) begin
      fault_latch_next = 1'b1;
      gates_on_next    = 1'b0;
      blink_phase_next = 11'd0;
      led_level_next   = scs_pkg::blink_level(11'd0);
    end else begin
      elapsed_ms_next = elapsed_inc;
      if (due) begin
        elapsed_ms_next   = 10'd0;
        stepped           = 1'b1;
        shown_sector_next = next_sector;
        gates_on_next     = 1'b1;
        if (cfg.reverse_direction) begin
          next_sector_next = (next_sector == 3'd0) ? 3'(scs_pkg::SectorCount - 1)
                                                   : next_sector - 3'd1;
        end else begin
          next_sector_next = (next_sector == 3'(scs_pkg::SectorCount - 1)) ? 3'd0
                                                                            : next_sector + 3'd1;
        end
        steps_at_dwell_next = step_wrap ? 12'd0 : steps_inc;
        if (step_wrap) begin
          sweep_index_next = idx_adv;
          idx_moved        = 1'b1;
        end
        led_level_next = ~led_level;
      end
    end

    result_next.gates            = gates_on_next ? scs_pkg::sector_gates(shown_sector_next) : 6'd0;
    result_next.status_led       = led_level_next;
    result_next.commutated       = stepped;
    result_next.safe_mode        = fault_latch_next;
    result_next.active_sector    = gates_on_next ? shown_sector_next : 3'd0;
    result_next.current_dwell_ms = idx_moved ? dwell_adv : dwell_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_sector    <= 3'd0;
      shown_sector   <= 3'd0;
      gates_on       <= 1'b0;
      elapsed_ms     <= 10'd0;
      sweep_index    <= 4'd0;
      steps_at_dwell <= 12'd0;
      fault_latch    <= 1'b0;
      blink_phase    <= 11'd0;
      led_level      <= 1'b1;
    end else if (accept) begin
      next_sector    <= next_sector_next;
      shown_sector   <= shown_sector_next;
      gates_on       <= gates_on_next;
      elapsed_ms     <= elapsed_ms_next;
      sweep_index    <= sweep_index_next;
      steps_at_dwell <= steps_at_dwell_next;
      fault_latch    <= fault_latch_next;
      blink_phase    <= blink_phase_next;
      led_level      <= led_level_next;
    end
  end

`ifndef SYNTH
  a_latch_sticky: assert property (@(posedge clk) disable iff (rst)
    fault_latch |=> fault_latch)
    else $error("fault latch cleared without reset");

  a_gates_off_safe: assert property (@(posedge clk) disable iff (rst)
    fault_latch |-> !gates_on)
    else $error("gates enabled in safe mode");

  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    (next_sector < 3'(scs_pkg::SectorCount)) && (shown_sector < 3'(scs_pkg::SectorCount)))
    else $error("sector out of range");

  a_blink_range: assert property (@(posedge clk) disable iff (rst)
    blink_phase < 11'(scs_pkg::BlinkPeriodMs))
    else $error("blink phase out of range");
`endif

endmodule

FILE: rtl/core/scs_out_fifo.sv
// two-word result buffer that decouples the tick input from the result output
module scs_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  scs_pkg::result_t push_word,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output scs_pkg::result_t head_word
);

  scs_pkg::result_t slot0, slot1;
  logic [1:0]       count;
  logic             pop;

  assign out_valid = count != 2'd0;
  assign full      = count == 2'd2;
  assign pop       = out_valid & ~out_stall;
  assign head_word = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // payload slots need no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count == 2'd1) begin
        slot0 <= push_word;
      end else begin
        slot0 <= slot1;
      end
      if (push && count == 2'd2) begin
        slot1 <= push_word;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_word;
      end else begin
        slot1 <= push_word;
      end
    end
  end

endmodule

FILE: rtl/core/six_step_commutation_sweeper.sv
// top level of the open-loop six-step commutation sweeper
// Open-loop six-step drive for a three-phase bridge, fed one tick word per
// millisecond carrying the active-low driver fault pin. Every tick returns exactly
// one result word with the six gate drives, the status LED, a commutation flag,
// the safe-mode flag, the driven sector and the dwell in force. A new tick word
// can be taken in every cycle while the buffer has room: the whole update is one
// pass of short logic from the state registers into a two-word result buffer,
// so the sustained rate is one word per cycle, and each result word is registered
// in that buffer, whose head word drives the outputs. in_stall rises only
// when both buffer words are held by a stalled output. Every dwell milliseconds
// the sector steps (down when reverse_direction is set, else up) and the LED
// toggles; after steps_per_dwell steps the sweep moves to its next entry, whose
// dwell is dwell_start_ms plus entry index times dwell_increment_ms, wrapping
// after dwell_count entries. The first step lands dwell ticks after reset, with
// all gates off until then. A tick with fault_n low latches safe mode until
// reset: gates off and the LED blinking 200 on, 200 off, 200 on, 800 off.
// Registers live at byte addresses 0, 4, 8, 12, 16 in the order start, increment,
// count, steps, direction, and take effect from the next tick.
module six_step_commutation_sweeper (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scs_pkg::AddrWidth-1:0] paddr,
  input  logic [scs_pkg::DataWidth-1:0] pwdata,
  output logic [scs_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  // tick word in
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          fault_n,
  // result word out
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          gate_ah,
  output logic                          gate_al,
  output logic                          gate_bh,
  output logic                          gate_bl,
  output logic                          gate_ch,
  output logic                          gate_cl,
  output logic                          status_led,
  output logic                          commutated,
  output logic                          safe_mode,
  output logic [2:0]                    active_sector,
  output logic [9:0]                    current_dwell_ms
);

  scs_pkg::cfg_t    cfg;
  scs_pkg::result_t result_next;
  scs_pkg::result_t head_word;
  logic             full;
  logic             accept;

  // a tick word is taken whenever the result buffer has room
  assign in_stall = full;
  assign accept   = in_valid & ~full;

  scs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // all per-tick state and its next-value logic
  scs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .fault_n     (fault_n),
    .result_next (result_next)
  );

  // result register plus skid word
  scs_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_word (result_next),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head_word (head_word)
  );

  // gate bit order: ah, al, bh, bl, ch, cl from the low end
  assign gate_ah          = head_word.gates[0];
  assign gate_al          = head_word.gates[1];
  assign gate_bh          = head_word.gates[2];
  assign gate_bl          = head_word.gates[3];
  assign gate_ch          = head_word.gates[4];
  assign gate_cl          = head_word.gates[5];
  assign status_led       = head_word.status_led;
  assign commutated       = head_word.commutated;
  assign safe_mode        = head_word.safe_mode;
  assign active_sector    = head_word.active_sector;
  assign current_dwell_ms = head_word.current_dwell_ms;

endmodule

FILE: verif/six_step_commutation_sweeper_tb.sv
// self-checking testbench for the six-step commutation sweeper
module six_step_commutation_sweeper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // share of cycles in which a side holds off
  localparam int unsigned IdlePct = 32;
  // LED blink pattern of safe mode, in ms
  localparam int unsigned BlinkOnMs    = 200;
  localparam int unsigned BlinkOffMs   = 200;
  localparam int unsigned BlinkPauseMs = 800;
  localparam int unsigned BlinkCycleMs = 2 * BlinkOnMs + BlinkOffMs + BlinkPauseMs;
  localparam int unsigned MaxEntries   = 16;
  localparam int unsigned MsCountMax   = 1023;
  // index with no register behind it
  localparam logic [2:0] UnmappedReg = 3'd6;
  // random words after the directed part
  localparam int unsigned RandomTicks = 140;
  // ticks spent in safe mode, past the first lit stretch of the blink
  localparam int unsigned SafeTicks = 220;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [scs_pkg::AddrWidth-1:0] paddr   = '0;
  logic [scs_pkg::DataWidth-1:0] pwdata  = '0;
  logic [scs_pkg::DataWidth-1:0] prdata;
  logic                          pready;

  logic in_valid  = 1'b0;
  logic in_stall;
  logic fault_n   = 1'b1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic gate_ah, gate_al, gate_bh, gate_bl, gate_ch, gate_cl;
  logic status_led, commutated, safe_mode;
  logic [2:0] active_sector;
  logic [9:0] current_dwell_ms;

  six_step_commutation_sweeper i_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .fault_n          (fault_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .gate_ah          (gate_ah),
    .gate_al          (gate_al),
    .gate_bh          (gate_bh),
    .gate_bl          (gate_bl),
    .gate_ch          (gate_ch),
    .gate_cl          (gate_cl),
    .status_led       (status_led),
    .commutated       (commutated),
    .safe_mode        (safe_mode),
    .active_sector    (active_sector),
    .current_dwell_ms (current_dwell_ms)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // tick words waiting to be driven, and predicted result words in order
  logic              pending_ticks[$];
  scs_pkg::result_t  expected_outputs[$];

  // bookkeeping shared by driver, monitor and sequence
  logic        word_taken = 1'b0;
  logic        steady     = 1'b0;
  int unsigned ticks_queued   = 0;
  int unsigned ticks_taken    = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned reg_writes     = 0;
  int unsigned steps_done     = 0;
  int unsigned entry_moves    = 0;
  int unsigned safe_ticks     = 0;
  int unsigned peak_dwell     = 0;

  // shadow of the register file, starts at the reset values
  scs_pkg::cfg_t sweep_cfg = '{dwell_start_ms: 6'd5, dwell_increment_ms: 6'd5,
                               dwell_count: 5'd10, steps_per_dwell: 12'd240,
                               reverse_direction: 1'b1};

  // commutation state as the block should hold it
  logic [2:0]  upcoming_sector = 3'd0;
  logic [2:0]  driven_sector   = 3'd0;
  logic        bridge_enabled  = 1'b0;
  int unsigned ms_count        = 0;
  logic [3:0]  entry_idx       = 4'd0;
  logic [11:0] entry_steps     = 12'd0;
  logic        fault_seen      = 1'b0;
  int unsigned blink_ms        = 0;
  logic        led_on          = 1'b1;

  // dwell of the entry in force, zero treated as one
  function automatic int unsigned dwell_now();
    int unsigned d;
    d = 32'(sweep_cfg.dwell_start_ms) + 32'(entry_idx) * 32'(sweep_cfg.dwell_increment_ms);
    return (d == 0) ? 1 : d;
  endfunction

  function automatic logic blink_on(input int unsigned phase);
    logic lvl;
    if (phase < BlinkOnMs) begin
      lvl = 1'b1;
    end else if (phase < BlinkOnMs + BlinkOffMs) begin
      lvl = 1'b0;
    end else if (phase < 2 * BlinkOnMs + BlinkOffMs) begin
      lvl = 1'b1;
    end else begin
      lvl = 1'b0;
    end
    return lvl;
  endfunction

  // bit order cl ch bl bh al ah
  function automatic logic [5:0] gate_pattern(input logic [2:0] sector);
    logic [5:0] g;
    case (sector)
      3'd0:    g = 6'b001001;  // ah + bl
      3'd1:    g = 6'b100001;  // ah + cl
      3'd2:    g = 6'b100100;  // bh + cl
      3'd3:    g = 6'b000110;  // bh + al
      3'd4:    g = 6'b010010;  // ch + al
      3'd5:    g = 6'b011000;  // ch + bl
      default: g = 6'b000000;
    endcase
    return g;
  endfunction

  // one millisecond tick through the drive model
  task automatic advance_drive_model(input logic tick_fault_n, output scs_pkg::result_t r);
    int unsigned entries;
    int unsigned steps_lim;
    logic        stepped;
    stepped = 1'b0;
    if (fault_seen) begin
      // latched: fault pin ignored, only the blink runs
      blink_ms = (blink_ms + 1) % BlinkCycleMs;
      led_on   = blink_on(blink_ms);
      safe_ticks++;
    end else if (!tick_fault_n) begin
      // fault beats any step due on this tick
      fault_seen     = 1'b1;
      bridge_enabled = 1'b0;
      blink_ms       = 0;
      led_on         = blink_on(0);
    end else begin
      if (ms_count < MsCountMax) ms_count++;
      if (ms_count >= dwell_now()) begin
        entries = (sweep_cfg.dwell_count == 0) ? 1 :
                  (sweep_cfg.dwell_count > MaxEntries) ? MaxEntries : sweep_cfg.dwell_count;
        steps_lim = (sweep_cfg.steps_per_dwell == 0) ? 1 : sweep_cfg.steps_per_dwell;
        ms_count       = 0;
        stepped        = 1'b1;
        driven_sector  = upcoming_sector;
        bridge_enabled = 1'b1;
        if (sweep_cfg.reverse_direction) begin
          upcoming_sector = (driven_sector == 3'd0) ? 3'd5 : driven_sector - 3'd1;
        end else begin
          upcoming_sector = (driven_sector == 3'd5) ? 3'd0 : driven_sector + 3'd1;
        end
        entry_steps = entry_steps + 12'd1;
        if (entry_steps >= steps_lim) begin
          // an index left above a lowered count only wraps here
          entry_steps = 12'd0;
          entry_idx   = entry_idx + 4'd1;
          if (entry_idx >= entries) entry_idx = 4'd0;
          entry_moves++;
        end
        led_on = !led_on;
        steps_done++;
      end
    end
    r.gates            = bridge_enabled ? gate_pattern(driven_sector) : 6'd0;
    r.status_led       = led_on;
    r.commutated       = stepped;
    r.safe_mode        = fault_seen;
    r.active_sector    = bridge_enabled ? driven_sector : 3'd0;
    r.current_dwell_ms = 10'(dwell_now());
    if (dwell_now() > peak_dwell) peak_dwell = dwell_now();
  endtask

  function automatic void compare_field(input string field, input logic [9:0] want_v,
                                        input logic [9:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // driver: new words and stalls change on the falling edge; a word not yet
  // taken is held as it is
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      fault_n   <= 1'b1;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || word_taken) begin
        if (pending_ticks.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePct)) begin
          in_valid <= 1'b1;
          fault_n  <= pending_ticks.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < IdlePct);
    end
  end

  // monitor: predict on every taken tick word, check every taken result word
  always @(posedge clk) begin
    scs_pkg::result_t predicted;
    scs_pkg::result_t oldest;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        advance_drive_model(fault_n, predicted);
        expected_outputs.push_back(predicted);
        ticks_taken++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_outputs.size() == 0) begin
          $error("result word with no tick word behind it");
          mismatch_count++;
        end else begin
          oldest = expected_outputs.pop_front();
          compare_field("gate_ah", 10'(oldest.gates[0]), 10'(gate_ah));
          compare_field("gate_al", 10'(oldest.gates[1]), 10'(gate_al));
          compare_field("gate_bh", 10'(oldest.gates[2]), 10'(gate_bh));
          compare_field("gate_bl", 10'(oldest.gates[3]), 10'(gate_bl));
          compare_field("gate_ch", 10'(oldest.gates[4]), 10'(gate_ch));
          compare_field("gate_cl", 10'(oldest.gates[5]), 10'(gate_cl));
          compare_field("status_led", 10'(oldest.status_led), 10'(status_led));
          compare_field("commutated", 10'(oldest.commutated), 10'(commutated));
          compare_field("safe_mode", 10'(oldest.safe_mode), 10'(safe_mode));
          compare_field("active_sector", 10'(oldest.active_sector), 10'(active_sector));
          compare_field("current_dwell_ms", oldest.current_dwell_ms, current_dwell_ms);
        end
      end
    end
  end

  // register write: setup then access, done once pready is seen in the access
  // cycle; bits above the register width sometimes carry junk
  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    int unsigned width;
    logic [31:0] mask;
    logic [31:0] data;
    case (idx)
      scs_pkg::REG_DWELL_START: begin
        width = 6;
        sweep_cfg.dwell_start_ms = value[5:0];
      end
      scs_pkg::REG_DWELL_INCREMENT: begin
        width = 6;
        sweep_cfg.dwell_increment_ms = value[5:0];
      end
      scs_pkg::REG_DWELL_COUNT: begin
        width = 5;
        sweep_cfg.dwell_count = value[4:0];
      end
      scs_pkg::REG_STEPS_PER_DWELL: begin
        width = 12;
        sweep_cfg.steps_per_dwell = value[11:0];
      end
      scs_pkg::REG_REVERSE: begin
        width = 1;
        sweep_cfg.reverse_direction = value[0];
      end
      default: begin
        width = 32;  // no register here, the write must change nothing
      end
    endcase
    mask = 32'hFFFF_FFFF >> (32 - width);
    data = value & mask;
    if ($urandom_range(0, 1) == 1) data = data | ($urandom() & ~mask);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  task automatic write_all_regs(input int unsigned start_ms, input int unsigned incr_ms,
                                input int unsigned entries, input int unsigned steps,
                                input int unsigned reverse);
    write_reg(scs_pkg::REG_DWELL_START, start_ms);
    write_reg(scs_pkg::REG_DWELL_INCREMENT, incr_ms);
    write_reg(scs_pkg::REG_DWELL_COUNT, entries);
    write_reg(scs_pkg::REG_STEPS_PER_DWELL, steps);
    write_reg(scs_pkg::REG_REVERSE, reverse);
  endtask

  task automatic queue_ticks(input int unsigned n);
    repeat (n) begin
      pending_ticks.push_back(1'b1);
      ticks_queued++;
    end
  endtask

  // every tick word taken and answered, then a short pause
  task automatic wait_idle();
    while (!(ticks_taken == ticks_queued && results_seen == ticks_taken)) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    int unsigned n;
    int unsigned phase_no;
    int unsigned random_done;
    int unsigned due;
    int unsigned pick;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset settings: gates stay off until the first step five ticks in
    queue_ticks(12);
    wait_idle();

    // zero dwell counts as one, count zero as one entry, zero steps as one;
    // sector walks upward every tick
    write_all_regs(0, 0, 0, 0, 0);
    queue_ticks(8);
    wait_idle();

    // a write to an address with no register is dropped
    write_reg(UnmappedReg, $urandom());
    queue_ticks(3);
    wait_idle();

    // walk the first sweep entries, one step per entry, downward
    write_all_regs(1, 1, 16, 1, 1);
    queue_ticks(40);
    wait_idle();

    // index left above a lowered count; the next entry move wraps it to zero
    write_reg(scs_pkg::REG_DWELL_COUNT, 4);
    queue_ticks(30);
    wait_idle();

    // widest start and increment, a dwell far longer than this run of ticks
    write_reg(scs_pkg::REG_DWELL_START, 63);
    write_reg(scs_pkg::REG_DWELL_INCREMENT, 63);
    queue_ticks(20);
    wait_idle();

    // count beyond range clamps to sixteen; step counter runs past a
    // steps limit written later, so the next step moves the entry
    write_all_regs(1, 0, 31, 4095, 0);
    queue_ticks(20);
    wait_idle();
    write_reg(scs_pkg::REG_STEPS_PER_DWELL, 5);
    queue_ticks(10);
    wait_idle();

    // random settings, mostly short dwells so the sector keeps moving
    phase_no    = 0;
    random_done = 0;
    while (random_done < RandomTicks) begin
      pick = $urandom_range(0, 9);
      write_all_regs(($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(0, 63),
                     ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 63),
                     $urandom_range(0, 31),
                     (pick < 6) ? $urandom_range(0, 4) :
                     (pick < 9) ? $urandom_range(5, 20) : $urandom_range(0, 4095),
                     $urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) write_reg(UnmappedReg, $urandom());
      // one phase runs with both sides at full rate
      n = (phase_no == 1) ? 80 : $urandom_range(20, 40);
      steady = (phase_no == 1);
      queue_ticks(n);
      wait_idle();
      steady = 1'b0;
      random_done += n;
      phase_no++;
    end

    // short fixed dwell, then a fault exactly on a tick where a step falls due
    write_reg(scs_pkg::REG_DWELL_START, 4);
    write_reg(scs_pkg::REG_DWELL_INCREMENT, 0);
    due = (dwell_now() > ms_count) ? dwell_now() - ms_count : 1;
    queue_ticks(due - 1);
    pending_ticks.push_back(1'b0);
    ticks_queued++;

    // safe mode ignores the pin; run past the first lit stretch of the blink
    repeat (SafeTicks) begin
      pending_ticks.push_back(1'($urandom_range(0, 1)));
      ticks_queued++;
    end
    wait_idle();
    repeat (8) @(posedge clk);

    if (expected_outputs.size() != 0) begin
      $error("%0d result words never arrived", expected_outputs.size());
      mismatch_count++;
    end

    $display("run covered %0d tick words, %0d register writes, %0d commutation steps,",
             ticks_taken, reg_writes, steps_done);
    $display("%0d entry moves, longest dwell %0d ms, %0d ticks in safe mode after the fault",
             entry_moves, peak_dwell, safe_ticks);
    if (mismatch_count == 0) begin
      $display("** six_step_commutation_sweeper: PASSED **");
    end else begin
      $display("** six_step_commutation_sweeper: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #400000;
    $display("** six_step_commutation_sweeper: FAILED **");
    $finish;
  end

endmodule
